// ===== hw/rtl/wav_pcm_stream_parser_macros.svh =====
// Assertion macros shared by the WAV stream parser RTL.
`ifndef WAV_PCM_STREAM_PARSER_MACROS_SVH
`define WAV_PCM_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WPSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WPSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wpsp_pkg.sv =====
// Types, constants and the control store of the WAV stream parser.
package wpsp_pkg;

    localparam int unsigned PC_W = 6;

    // Step addresses. Steps 0..43 consume the header bytes one per step.
    localparam logic [PC_W-1:0] PC_FIRST     = 6'd0;
    localparam logic [PC_W-1:0] POS_RIFF     = 6'd3;
    localparam logic [PC_W-1:0] POS_WAVE     = 6'd11;
    localparam logic [PC_W-1:0] POS_FMT      = 6'd15;
    localparam logic [PC_W-1:0] POS_FMT_SIZE = 6'd19;
    localparam logic [PC_W-1:0] POS_CHANNELS = 6'd23;
    localparam logic [PC_W-1:0] POS_RATE     = 6'd27;
    localparam logic [PC_W-1:0] POS_BITS     = 6'd35;
    localparam logic [PC_W-1:0] POS_DATA     = 6'd39;
    localparam logic [PC_W-1:0] POS_LAST     = 6'd43;
    localparam logic [PC_W-1:0] PC_ZCHK      = 6'd44;
    localparam logic [PC_W-1:0] PC_DIV       = 6'd45;
    localparam logic [PC_W-1:0] PC_HOUT      = 6'd46;
    localparam logic [PC_W-1:0] PC_SAMP      = 6'd47;
    localparam logic [PC_W-1:0] PC_HALT      = 6'd48;

    // Little-endian tag words as they sit in the assembly register.
    localparam logic [31:0] TAG_RIFF  = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE  = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT   = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA  = 32'h6174_6164;
    localparam logic [31:0] FMT_SIZE  = 32'd16;

    localparam logic [15:0] BITS_8  = 16'd8;
    localparam logic [15:0] BITS_16 = 16'd16;
    localparam logic [15:0] BITS_32 = 16'd32;

    localparam int unsigned DIVIDEND_W = 32;
    localparam int unsigned DIVISOR_W  = 29;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_RIFF     = 3'd1,
        ERR_WAVE     = 3'd2,
        ERR_FMT_TAG  = 3'd3,
        ERR_FMT_SIZE = 3'd4,
        ERR_DATA_TAG = 3'd5,
        ERR_ZERO_DIV = 3'd6
    } err_code_t;

    typedef enum logic [3:0] {
        OP_SHIFT      = 4'd0,
        OP_CHECK_TAG  = 4'd1,
        OP_CAP_CH     = 4'd2,
        OP_CAP_RATE   = 4'd3,
        OP_CAP_BITS   = 4'd4,
        OP_ZERO_CHECK = 4'd5,
        OP_DIV_WAIT   = 4'd6,
        OP_HDR_OUT    = 4'd7,
        OP_SAMPLE     = 4'd8,
        OP_IGNORE     = 4'd9
    } op_t;

    // One control word: does the step take a byte, what it does, where it goes.
    typedef struct packed {
        logic            wait_byte;
        op_t             op;
        err_code_t       code;
        logic [PC_W-1:0] next;
        logic [PC_W-1:0] alt;
    } ucode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } byte_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [2:0]         error_code;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [15:0]        sample_bits;
        logic [31:0]        frame_count;
        logic [15:0]        channel_index;
        logic signed [31:0] sample_value;
        logic               last_sample;
    } result_t;

    // Expected word for each header check.
    function automatic logic [31:0] tag_value(input err_code_t code);
        logic [31:0] v;
        unique case (code)
            ERR_RIFF:     v = TAG_RIFF;
            ERR_WAVE:     v = TAG_WAVE;
            ERR_FMT_TAG:  v = TAG_FMT;
            ERR_FMT_SIZE: v = FMT_SIZE;
            ERR_DATA_TAG: v = TAG_DATA;
            default:      v = '0;
        endcase
        return v;
    endfunction

    // Control store.
    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t w;
        w.wait_byte = 1'b1;
        w.op        = OP_SHIFT;
        w.code      = ERR_NONE;
        w.next      = pc + 6'd1;
        w.alt       = PC_HALT;
        case (pc) inside
            POS_RIFF:     begin w.op = OP_CHECK_TAG; w.code = ERR_RIFF;     end
            POS_WAVE:     begin w.op = OP_CHECK_TAG; w.code = ERR_WAVE;     end
            POS_FMT:      begin w.op = OP_CHECK_TAG; w.code = ERR_FMT_TAG;  end
            POS_FMT_SIZE: begin w.op = OP_CHECK_TAG; w.code = ERR_FMT_SIZE; end
            POS_DATA:     begin w.op = OP_CHECK_TAG; w.code = ERR_DATA_TAG; end
            POS_CHANNELS: w.op = OP_CAP_CH;
            POS_RATE:     w.op = OP_CAP_RATE;
            POS_BITS:     w.op = OP_CAP_BITS;
            POS_LAST:     w.next = PC_ZCHK;
            [PC_FIRST:POS_LAST]: w.op = OP_SHIFT;
            PC_ZCHK:
            begin
                w.wait_byte = 1'b0;
                w.op        = OP_ZERO_CHECK;
                w.code      = ERR_ZERO_DIV;
                w.next      = PC_DIV;
            end
            PC_DIV:
            begin
                w.wait_byte = 1'b0;
                w.op        = OP_DIV_WAIT;
                w.next      = PC_HOUT;
            end
            PC_HOUT:
            begin
                w.wait_byte = 1'b0;
                w.op        = OP_HDR_OUT;
                w.next      = PC_SAMP;
            end
            PC_SAMP:
            begin
                w.op   = OP_SAMPLE;
                w.next = PC_SAMP;
            end
            default:
            begin
                w.op   = OP_IGNORE;
                w.next = PC_HALT;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/wpsp_divider.sv =====
// Bit-serial restoring divider for the frame count, one quotient bit per cycle.
module wpsp_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [wpsp_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [wpsp_pkg::DIVISOR_W-1:0]       divisor,
    output logic                                 done,
    output logic [wpsp_pkg::DIVIDEND_W-1:0]      quotient
);
    import wpsp_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== hw/rtl/wav_pcm_stream_parser.sv =====
// Top level of the WAV stream parser: microcoded sequencer and output register.
// Takes a WAV file one byte per request and reads the 44-byte RIFF/WAVE header,
// checking the RIFF, WAVE, "fmt " and "data" tags and a format size of 16; a
// failed check gives one error result, after which bytes are dropped until the
// next byte flagged file_start. After the last header byte byte_ready stays low
// through the zero check, the bit-serial frame-count divider (one quotient bit
// per cycle) and the posting of the header result. Header and sample bytes are
// otherwise taken one per cycle while the output register is empty or draining.
// For 8, 16 and 32-bit depths each sample comes out left-aligned as two's
// complement Q1.31 with its channel, the final one marked last_sample.
// Results wait in one output register; a new byte is taken while it drains.
`include "wav_pcm_stream_parser_macros.svh"

module wav_pcm_stream_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  wpsp_pkg::byte_t   byte_data,
    output logic              result_valid,
    input  logic              result_ready,
    output wpsp_pkg::result_t result_data
);
    import wpsp_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [31:0]     asm_reg, asm_next;
    logic [15:0]     ch_reg, ch_next;
    logic [31:0]     rate_reg, rate_next;
    logic [15:0]     bits_reg, bits_next;
    logic [31:0]     frames_reg, frames_next;
    logic [1:0]      bis_reg, bis_next;
    logic [15:0]     cur_reg, cur_next;
    logic            result_valid_reg, result_valid_next;
    result_t         result_reg, result_next;

    logic            slot_free;
    logic            take;
    logic            fs;
    logic [PC_W-1:0] pc_x;
    ucode_t          uw_cur;
    ucode_t          uw;
    logic [31:0]     shifted;
    logic            emit;
    result_t         out_word;
    logic [12:0]     width;
    logic [16:0]     cur_plus;
    logic [31:0]     frames_dec;
    logic            bits_ok;
    logic            div_start;
    logic            div_done;
    logic [31:0]     div_quot;
    logic [DIVISOR_W-1:0] div_divisor;

    // Handshake
    assign slot_free  = !result_valid_reg || result_ready;
    assign uw_cur     = ucode(pc_reg);
    assign byte_ready = uw_cur.wait_byte && slot_free;
    assign take       = byte_valid && byte_ready;
    assign fs         = take && byte_data.file_start;

    // A new file restarts the program at the first header byte.
    assign pc_x    = fs ? PC_FIRST : pc_reg;
    assign uw      = ucode(pc_x);
    assign shifted = {byte_data.data_byte, (fs ? 24'd0 : asm_reg[31:8])};

    assign width       = bits_reg[15:3];
    assign div_divisor = {16'd0, width} * {13'd0, ch_reg};
    assign cur_plus    = {1'b0, cur_reg} + 17'd1;
    assign frames_dec  = frames_reg - 32'd1;
    assign bits_ok     = bits_reg == BITS_8 || bits_reg == BITS_16 || bits_reg == BITS_32;

    wpsp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (asm_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Execute the current control word
    always_comb
    begin
        pc_next     = pc_reg;
        asm_next    = asm_reg;
        ch_next     = ch_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        frames_next = frames_reg;
        bis_next    = bis_reg;
        cur_next    = cur_reg;
        emit        = 1'b0;
        out_word    = '0;
        div_start   = 1'b0;
        unique case (uw.op)
            OP_SHIFT:
            begin
                if (take)
                begin
                    asm_next = shifted;
                    pc_next  = uw.next;
                end
            end
            OP_CHECK_TAG:
            begin
                if (take)
                begin
                    asm_next = shifted;
                    if (shifted != tag_value(uw.code))
                    begin
                        emit                = 1'b1;
                        out_word.result_kind = KIND_ERROR;
                        out_word.error_code  = uw.code;
                        pc_next             = uw.alt;
                    end
                    else
                    begin
                        pc_next = uw.next;
                    end
                end
            end
            OP_CAP_CH:
            begin
                if (take)
                begin
                    asm_next = shifted;
                    ch_next  = shifted[31:16];
                    pc_next  = uw.next;
                end
            end
            OP_CAP_RATE:
            begin
                if (take)
                begin
                    asm_next  = shifted;
                    rate_next = shifted;
                    pc_next   = uw.next;
                end
            end
            OP_CAP_BITS:
            begin
                if (take)
                begin
                    asm_next  = shifted;
                    bits_next = shifted[31:16];
                    pc_next   = uw.next;
                end
            end
            OP_ZERO_CHECK:
            begin
                if (width == '0 || ch_reg == '0)
                begin
                    if (slot_free)
                    begin
                        emit                 = 1'b1;
                        out_word.result_kind = KIND_ERROR;
                        out_word.error_code  = uw.code;
                        pc_next              = uw.alt;
                    end
                end
                else
                begin
                    div_start = 1'b1;
                    pc_next   = uw.next;
                end
            end
            OP_DIV_WAIT:
            begin
                if (div_done)
                begin
                    frames_next = div_quot;
                    pc_next     = uw.next;
                end
            end
            OP_HDR_OUT:
            begin
                if (slot_free)
                begin
                    emit                   = 1'b1;
                    out_word.result_kind   = KIND_HEADER;
                    out_word.channel_count = ch_reg;
                    out_word.sample_rate   = rate_reg;
                    out_word.sample_bits   = bits_reg;
                    out_word.frame_count   = frames_reg;
                    asm_next               = '0;
                    bis_next               = '0;
                    cur_next               = '0;
                    pc_next = (frames_reg != '0 && bits_ok) ? uw.next : uw.alt;
                end
            end
            OP_SAMPLE:
            begin
                if (take)
                begin
                    asm_next = shifted;
                    if ({1'b0, bis_reg} + 3'd1 < width[2:0])
                    begin
                        bis_next = bis_reg + 2'd1;
                    end
                    else
                    begin
                        emit                   = 1'b1;
                        out_word.result_kind   = KIND_SAMPLE;
                        out_word.channel_index = cur_reg;
                        out_word.sample_value  = shifted;
                        out_word.last_sample   = frames_reg == 32'd1 && cur_plus == {1'b0, ch_reg};
                        asm_next               = '0;
                        bis_next               = '0;
                        // Wrap the channel at the end of a frame.
                        if (cur_plus >= {1'b0, ch_reg})
                        begin
                            cur_next    = '0;
                            frames_next = frames_dec;
                            if (frames_dec == '0)
                            begin
                                pc_next = uw.alt;
                            end
                        end
                        else
                        begin
                            cur_next = cur_plus[15:0];
                        end
                    end
                end
            end
            OP_IGNORE:
            begin
                pc_next = uw.next;
            end
            default:
            begin
                pc_next = PC_HALT;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (emit)
        begin
            result_valid_next = 1'b1;
            result_next       = out_word;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= PC_FIRST;
            bis_reg          <= '0;
            cur_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg           <= pc_next;
            bis_reg          <= bis_next;
            cur_reg          <= cur_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        asm_reg    <= asm_next;
        ch_reg     <= ch_next;
        rate_reg   <= rate_next;
        bits_reg   <= bits_next;
        frames_reg <= frames_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // Checks
    `WPSP_ASSERT_NOW(a_emit_slot_free, clk, rst_n, emit, slot_free, "result overwritten while still pending")
    `WPSP_ASSERT_NOW(a_done_in_div, clk, rst_n, div_done, pc_reg == PC_DIV, "divider finished outside the wait step")
    `WPSP_ASSERT_NEXT(a_start_to_div, clk, rst_n, div_start, pc_reg == PC_DIV && !byte_ready, "no wait step after divider start")
    `WPSP_ASSERT_NOW(a_sample_in_phase, clk, rst_n, emit && out_word.result_kind == KIND_SAMPLE, pc_reg == PC_SAMP && !fs, "sample emitted outside the sample step")

endmodule
